@@ rtl/cmc_pkg.sv @@
`default_nettype none
package cmc_pkg;

  localparam int X_W    = 11;
  localparam int Y_W    = 11;
  localparam int CH_W   = 8;
  localparam int THR_W  = 17;
  localparam int SP_W   = 8;
  localparam int DIM_W  = 12;
  localparam int CNT_W  = 23;
  localparam int SUM_W  = 34;
  localparam int DIST_W = 17;
  localparam int BND_W  = 14;   // holds any bound up to 8192

  localparam logic [CNT_W-1:0] COUNT_MAX = {CNT_W{1'b1}};

  localparam int CFG_ADDR_W = 5;
  localparam int CFG_DATA_W = 32;

  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = 2;

  typedef enum logic [2:0] {
    REG_TARGET_U  = 3'd0,
    REG_TARGET_V  = 3'd1,
    REG_THRESHOLD = 3'd2,
    REG_SPACING   = 3'd3,
    REG_WIDTH     = 3'd4,
    REG_HEIGHT    = 3'd5
  } reg_idx_t;

  typedef struct packed {
    logic [CH_W-1:0]  target_u;
    logic [CH_W-1:0]  target_v;
    logic [THR_W-1:0] match_threshold;
    logic [SP_W-1:0]  sample_spacing;
    logic [DIM_W-1:0] frame_width;
    logic [DIM_W-1:0] frame_height;
  } cfg_t;

  typedef struct packed {
    logic [X_W-1:0] px;
    logic [Y_W-1:0] py;
    logic           hit;
    logic           last;
  } entry_t;

endpackage
`default_nettype wire

@@ rtl/cmc_pixel_if.sv @@
`default_nettype none
interface cmc_pixel_if;
  logic                      valid;
  logic                      ready;
  logic [cmc_pkg::X_W-1:0]   pixel_x;
  logic [cmc_pkg::Y_W-1:0]   pixel_y;
  logic [cmc_pkg::CH_W-1:0]  pixel_u;
  logic [cmc_pkg::CH_W-1:0]  pixel_v;
  logic                      last_pixel;

  modport source (output valid, pixel_x, pixel_y, pixel_u, pixel_v, last_pixel,
                  input ready);
  modport sink   (input valid, pixel_x, pixel_y, pixel_u, pixel_v, last_pixel,
                  output ready);
endinterface
`default_nettype wire

@@ rtl/cmc_result_if.sv @@
`default_nettype none
interface cmc_result_if;
  logic                       valid;
  logic                       ready;
  logic [cmc_pkg::CNT_W-1:0]  match_count;
  logic [cmc_pkg::X_W-1:0]    mean_col;
  logic [cmc_pkg::Y_W-1:0]    mean_row;

  modport source (output valid, match_count, mean_col, mean_row, input ready);
  modport sink   (input valid, match_count, mean_col, mean_row, output ready);
endinterface
`default_nettype wire

@@ rtl/cmc_front.sv @@
`default_nettype none
module cmc_front #(
  parameter int MAX_WIDTH  = 2048,
  parameter int MAX_HEIGHT = 2048
) (
  input  wire                 clk,
  input  wire                 rst,
  cmc_pixel_if.sink           pix,
  input  cmc_pkg::cfg_t       cfg,
  output cmc_pkg::entry_t     push_data,
  output logic                push,
  input  wire                 full
);

  localparam logic [cmc_pkg::BND_W-1:0] LIM_X = cmc_pkg::BND_W'(MAX_WIDTH);
  localparam logic [cmc_pkg::BND_W-1:0] LIM_Y = cmc_pkg::BND_W'(MAX_HEIGHT);

  typedef enum logic [1:0] {ST_IDLE, ST_MOD, ST_PUSH} state_t;

  state_t                      state;
  logic [1:0]                  step;
  logic [cmc_pkg::X_W-1:0]     px;
  logic [cmc_pkg::Y_W-1:0]     py;
  logic [cmc_pkg::CH_W-1:0]    pu;
  logic [cmc_pkg::CH_W-1:0]    pv;
  logic                        last;
  logic [11:0]                 x_sh;
  logic [11:0]                 y_sh;
  logic [cmc_pkg::SP_W-1:0]    rem_x;
  logic [cmc_pkg::SP_W-1:0]    rem_y;
  logic [cmc_pkg::DIST_W-1:0]  chroma_dist;

  logic                        accept;
  logic [cmc_pkg::CH_W-1:0]    du;
  logic [cmc_pkg::CH_W-1:0]    dv;
  logic [cmc_pkg::SP_W-2:0]    half;
  logic [cmc_pkg::BND_W-1:0]   bound_x;
  logic [cmc_pkg::BND_W-1:0]   bound_y;
  logic                        x_ok;
  logic                        y_ok;
  logic                        sampled;

  // four restoring steps of c mod s; for nonzero s, rem stays below s throughout
  function automatic logic [cmc_pkg::SP_W-1:0] mod_step4(
    input logic [cmc_pkg::SP_W-1:0] rem_in,
    input logic [3:0]               bits,
    input logic [cmc_pkg::SP_W-1:0] s
  );
    logic [cmc_pkg::SP_W:0] r;
    r = {1'b0, rem_in};
    for (int i = 3; i >= 0; i--) begin
      r = {r[cmc_pkg::SP_W-1:0], bits[i]};
      if (r >= {1'b0, s}) begin
        r = r - {1'b0, s};
      end
    end
    return r[cmc_pkg::SP_W-1:0];
  endfunction

  assign pix.ready = (state == ST_IDLE) || ((state == ST_PUSH) && !full);
  assign accept    = pix.valid && pix.ready;
  assign push      = (state == ST_PUSH) && !full;

  assign du = (pu > cfg.target_u) ? pu - cfg.target_u : cfg.target_u - pu;
  assign dv = (pv > cfg.target_v) ? pv - cfg.target_v : cfg.target_v - pv;

  assign half    = cfg.sample_spacing[cmc_pkg::SP_W-1:1];
  assign bound_x = ({2'b0, cfg.frame_width} > LIM_X) ? LIM_X : {2'b0, cfg.frame_width};
  assign bound_y = ({2'b0, cfg.frame_height} > LIM_Y) ? LIM_Y : {2'b0, cfg.frame_height};
  assign x_ok    = ({3'b0, px} + {7'b0, half}) <= bound_x;
  assign y_ok    = ({3'b0, py} + {7'b0, half}) <= bound_y;
  assign sampled = (cfg.sample_spacing != '0) && (rem_x == {1'b0, half}) &&
                   (rem_y == {1'b0, half}) && x_ok && y_ok;

  always_comb begin
    push_data.px   = px;
    push_data.py   = py;
    push_data.hit  = sampled && (chroma_dist < cfg.match_threshold);
    push_data.last = last;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      step  <= '0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (accept) begin
            state <= ST_MOD;
            step  <= '0;
          end
        end
        ST_MOD: begin
          step <= step + 2'd1;
          if (step == 2'd2) begin
            state <= ST_PUSH;
          end
        end
        ST_PUSH: begin
          if (!full) begin
            state <= accept ? ST_MOD : ST_IDLE;
            step  <= '0;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      px    <= pix.pixel_x;
      py    <= pix.pixel_y;
      pu    <= pix.pixel_u;
      pv    <= pix.pixel_v;
      last  <= pix.last_pixel;
      x_sh  <= {1'b0, pix.pixel_x};
      y_sh  <= {1'b0, pix.pixel_y};
      rem_x <= '0;
      rem_y <= '0;
    end else if (state == ST_MOD) begin
      rem_x <= mod_step4(rem_x, x_sh[11:8], cfg.sample_spacing);
      rem_y <= mod_step4(rem_y, y_sh[11:8], cfg.sample_spacing);
      x_sh  <= {x_sh[7:0], 4'b0};
      y_sh  <= {y_sh[7:0], 4'b0};
      chroma_dist <= cmc_pkg::DIST_W'(16'(du) * 16'(du)) +
                     cmc_pkg::DIST_W'(16'(dv) * 16'(dv));
    end
  end

endmodule
`default_nettype wire

@@ rtl/cmc_queue.sv @@
`default_nettype none
module cmc_queue (
  input  wire              clk,
  input  wire              rst,
  input  wire              push,
  input  cmc_pkg::entry_t  push_data,
  input  wire              pop,
  output cmc_pkg::entry_t  pop_data,
  output logic             full,
  output logic             empty
);

  cmc_pkg::entry_t               mem [cmc_pkg::QUEUE_DEPTH];
  logic [cmc_pkg::QPTR_W-1:0]    wr_ptr;
  logic [cmc_pkg::QPTR_W-1:0]    rd_ptr;
  logic [cmc_pkg::QPTR_W:0]      fill;

  assign full     = fill == (cmc_pkg::QPTR_W+1)'(cmc_pkg::QUEUE_DEPTH);
  assign empty    = fill == '0;
  assign pop_data = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        fill <= fill + 1'b1;
      end else if (pop && !push) begin
        fill <= fill - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst) push |-> !full)
    else $error("queue written while full");
  a_no_underflow: assert property (@(posedge clk) disable iff (rst) pop |-> !empty)
    else $error("queue read while empty");

endmodule
`default_nettype wire

@@ rtl/cmc_back.sv @@
`default_nettype none
module cmc_back (
  input  wire              clk,
  input  wire              rst,
  input  cmc_pkg::entry_t  pop_data,
  input  wire              empty,
  output logic             pop,
  cmc_result_if.source     res
);

  typedef enum logic [1:0] {ST_ACC, ST_DIV, ST_HOLD} state_t;

  state_t                        state;
  logic [cmc_pkg::SUM_W-1:0]     sum_cols;
  logic [cmc_pkg::SUM_W-1:0]     sum_rows;
  logic [cmc_pkg::CNT_W-1:0]     hit_count;
  logic [cmc_pkg::SUM_W-1:0]     rem_x;
  logic [cmc_pkg::SUM_W-1:0]     rem_y;
  logic [cmc_pkg::SUM_W-1:0]     dsr;
  logic [cmc_pkg::CNT_W-1:0]     div_cnt;
  logic [cmc_pkg::X_W-1:0]       qx;
  logic [cmc_pkg::Y_W-1:0]       qy;
  logic [3:0]                    step;
  logic                          out_valid;
  logic [cmc_pkg::CNT_W-1:0]     out_count;
  logic [cmc_pkg::X_W-1:0]       out_x;
  logic [cmc_pkg::Y_W-1:0]       out_y;

  logic                          take;
  logic [cmc_pkg::SUM_W-1:0]     sum_cols_next;
  logic [cmc_pkg::SUM_W-1:0]     sum_rows_next;
  logic [cmc_pkg::CNT_W-1:0]     hit_count_next;
  logic                          ge_x;
  logic                          ge_y;
  logic                          load_out;

  assign pop  = (state == ST_ACC) && !empty;
  assign take = pop && pop_data.hit && (hit_count != cmc_pkg::COUNT_MAX);

  assign sum_cols_next  = take ? sum_cols + cmc_pkg::SUM_W'(pop_data.px) : sum_cols;
  assign sum_rows_next  = take ? sum_rows + cmc_pkg::SUM_W'(pop_data.py) : sum_rows;
  assign hit_count_next = take ? hit_count + 1'b1 : hit_count;

  assign ge_x     = rem_x >= dsr;
  assign ge_y     = rem_y >= dsr;
  assign load_out = (state == ST_HOLD) && (!out_valid || res.ready);

  assign res.valid       = out_valid;
  assign res.match_count = out_count;
  assign res.mean_col    = out_x;
  assign res.mean_row    = out_y;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_ACC;
      sum_cols  <= '0;
      sum_rows  <= '0;
      hit_count <= '0;
      out_valid <= 1'b0;
      step      <= '0;
    end else begin
      if (out_valid && res.ready && !load_out) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_ACC: begin
          if (pop) begin
            if (pop_data.last) begin
              // close the frame: hand the totals to the divider, clear sums
              rem_x     <= sum_cols_next;
              rem_y     <= sum_rows_next;
              div_cnt   <= hit_count_next;
              dsr       <= cmc_pkg::SUM_W'({hit_count_next, 10'b0});
              qx        <= '0;
              qy        <= '0;
              step      <= '0;
              sum_cols  <= '0;
              sum_rows  <= '0;
              hit_count <= '0;
              state     <= (hit_count_next == '0) ? ST_HOLD : ST_DIV;
            end else begin
              sum_cols  <= sum_cols_next;
              sum_rows  <= sum_rows_next;
              hit_count <= hit_count_next;
            end
          end
        end
        ST_DIV: begin
          if (ge_x) begin
            rem_x <= rem_x - dsr;
          end
          if (ge_y) begin
            rem_y <= rem_y - dsr;
          end
          qx   <= {qx[cmc_pkg::X_W-2:0], ge_x};
          qy   <= {qy[cmc_pkg::Y_W-2:0], ge_y};
          dsr  <= dsr >> 1;
          step <= step + 4'd1;
          if (step == 4'(cmc_pkg::X_W - 1)) begin
            state <= ST_HOLD;
          end
        end
        ST_HOLD: begin
          if (load_out) begin
            out_valid <= 1'b1;
            out_count <= div_cnt;
            out_x     <= qx;
            out_y     <= qy;
            state     <= ST_ACC;
          end
        end
        default: state <= ST_ACC;
      endcase
    end
  end

  a_div_nonzero: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DIV) |-> (div_cnt != '0))
    else $error("divider running on a zero count");
  a_empty_frame: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (out_count == '0)) |-> ((out_x == '0) && (out_y == '0)))
    else $error("centroid not zero for a frame without matches");
  a_step_range: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DIV) |-> (step < 4'(cmc_pkg::X_W)))
    else $error("divider step counter out of range");

endmodule
`default_nettype wire

@@ rtl/chroma_match_centroid.sv @@
`default_nettype none
// Channel     Dir  Beat payload                                        Handshake
// pixel_in    in   pixel_x, pixel_y, pixel_u, pixel_v, last_pixel      valid/ready
// result_out  out  match_count, mean_col, mean_row                     valid/ready
// apb         in   six config registers at byte offsets 0x00..0x14     psel/penable, pready=1
//
// A pixel passes through ST_MOD and ST_PUSH in the front end: grid position c mod
// spacing is resolved 4 bits per cycle in ST_MOD, then the classified beat is queued.
// The back end consumes one queued beat per cycle while in ST_ACC; on the last pixel
// of a frame it runs a restoring divide (skipped when nothing matched), then waits
// in ST_HOLD until the result register is free to load the result.
// Reset (rst, synchronous) restores register defaults and clears sums and queue.
// A stalled result_out holds the back end only; the front keeps accepting until
// four beats wait in the queue and one more sits classified in the front end.
module chroma_match_centroid #(
  parameter int MAX_WIDTH  = 2048,
  parameter int MAX_HEIGHT = 2048
) (
  input  wire                               clk,
  input  wire                               rst,
  input  wire                               psel,
  input  wire                               penable,
  input  wire                               pwrite,
  input  wire  [cmc_pkg::CFG_ADDR_W-1:0]    paddr,
  input  wire  [cmc_pkg::CFG_DATA_W-1:0]    pwdata,
  output logic [cmc_pkg::CFG_DATA_W-1:0]    prdata,
  output logic                              pready,
  cmc_pixel_if.sink                         pixel_in,
  cmc_result_if.source                      result_out
);

  cmc_pkg::cfg_t     cfg;
  cmc_pkg::reg_idx_t reg_idx;
  cmc_pkg::entry_t   push_data;
  cmc_pkg::entry_t   pop_data;
  logic              cfg_write;
  logic              push;
  logic              pop;
  logic              full;
  logic              empty;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;
  assign reg_idx   = cmc_pkg::reg_idx_t'(paddr[4:2]);

  // register file; the user must write only while the pipeline is drained, the block does not enforce it
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.target_u        <= 8'd120;
      cfg.target_v        <= 8'd197;
      cfg.match_threshold <= 17'd1024;
      cfg.sample_spacing  <= 8'd8;
      cfg.frame_width     <= 12'd1280;
      cfg.frame_height    <= 12'd720;
    end else if (cfg_write) begin
      case (reg_idx)
        cmc_pkg::REG_TARGET_U:  cfg.target_u        <= pwdata[cmc_pkg::CH_W-1:0];
        cmc_pkg::REG_TARGET_V:  cfg.target_v        <= pwdata[cmc_pkg::CH_W-1:0];
        cmc_pkg::REG_THRESHOLD: cfg.match_threshold <= pwdata[cmc_pkg::THR_W-1:0];
        cmc_pkg::REG_SPACING:   cfg.sample_spacing  <= pwdata[cmc_pkg::SP_W-1:0];
        cmc_pkg::REG_WIDTH:     cfg.frame_width     <= pwdata[cmc_pkg::DIM_W-1:0];
        cmc_pkg::REG_HEIGHT:    cfg.frame_height    <= pwdata[cmc_pkg::DIM_W-1:0];
        default: ;
      endcase
    end
  end

  // read back, zero-extended; unused offsets read as zero
  always_comb begin
    case (reg_idx)
      cmc_pkg::REG_TARGET_U:  prdata = cmc_pkg::CFG_DATA_W'(cfg.target_u);
      cmc_pkg::REG_TARGET_V:  prdata = cmc_pkg::CFG_DATA_W'(cfg.target_v);
      cmc_pkg::REG_THRESHOLD: prdata = cmc_pkg::CFG_DATA_W'(cfg.match_threshold);
      cmc_pkg::REG_SPACING:   prdata = cmc_pkg::CFG_DATA_W'(cfg.sample_spacing);
      cmc_pkg::REG_WIDTH:     prdata = cmc_pkg::CFG_DATA_W'(cfg.frame_width);
      cmc_pkg::REG_HEIGHT:    prdata = cmc_pkg::CFG_DATA_W'(cfg.frame_height);
      default:                prdata = '0;
    endcase
  end

  // front end: grid test and chroma distance, one pixel at a time
  cmc_front #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .pix       (pixel_in),
    .cfg       (cfg),
    .push_data (push_data),
    .push      (push),
    .full      (full)
  );

  // decouple classification from accumulation and result stalls
  cmc_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .pop_data  (pop_data),
    .full      (full),
    .empty     (empty)
  );

  // back end: accumulate matches, divide at frame end, hold the result
  cmc_back u_back (
    .clk      (clk),
    .rst      (rst),
    .pop_data (pop_data),
    .empty    (empty),
    .pop      (pop),
    .res      (result_out)
  );

endmodule
`default_nettype wire

@@ test/testbench.sv @@
`timescale 1ns / 100ps
module testbench;
  import cmc_pkg::*;

  // Frame bounds are clipped to this limit, same as the block's default parameters.
  localparam int unsigned FRAME_LIMIT  = 2048;
  // Cycles to let a pixel with no result work its way through.
  // The front end, the beat queue, the divide and the result load fit well inside.
  localparam int unsigned DRAIN_CYCLES = 64;
  localparam int unsigned RANDOM_ITEMS = 1130;
  localparam int unsigned PHASES       = 8;
  localparam int unsigned TIMEOUT_NS   = 3_000_000;

  typedef struct {
    logic [CNT_W-1:0] count;
    logic [X_W-1:0]   col;
    logic [Y_W-1:0]   row;
  } centroid_t;

  logic clk;
  logic rst;
  logic psel;
  logic penable;
  logic pwrite;
  logic [CFG_ADDR_W-1:0] paddr;
  logic [CFG_DATA_W-1:0] pwdata;
  logic [CFG_DATA_W-1:0] prdata;
  logic pready;

  cmc_pixel_if  pixel_in ();
  cmc_result_if result_out ();

  chroma_match_centroid i_dut (
    .clk        (clk),
    .rst        (rst),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready),
    .pixel_in   (pixel_in),
    .result_out (result_out)
  );

  // Shadow copy of the registers and of the frame accumulators.
  cfg_t             shadow_cfg;
  logic [SUM_W-1:0] col_sum;
  logic [SUM_W-1:0] row_sum;
  logic [CNT_W-1:0] hit_total;

  // Centroids still owed by the block, oldest first.
  centroid_t pending_centroids[$];

  int unsigned sender_idle_pct;
  int unsigned sink_stall_pct;
  int unsigned error_count;
  int unsigned pixels_accepted;
  int unsigned results_seen;
  int unsigned settings_used;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Hard stop: far beyond the slowest legal run.
  initial begin
    #(TIMEOUT_NS);
    $display("tb: failure");
    $finish;
  end

  task automatic log_mismatch(input string what);
    $display("%0t ns: mismatch: %s", $time, what);
    error_count++;
  endtask

  // Grid test on one axis: spacing zero samples nothing, the bound is clipped
  // to the frame limit, and the sample must sit half a spacing inside the bound.
  function automatic bit lies_on_grid(input int unsigned c, input int unsigned s,
                                      input int unsigned bound);
    int unsigned half;
    if (s == 0) return 1'b0;
    if (bound > FRAME_LIMIT) bound = FRAME_LIMIT;
    half = s / 2;
    if (c % s != half) return 1'b0;
    return (c + half <= bound);
  endfunction

  // Fold one accepted pixel into the shadow sums; on the last pixel of a
  // frame queue the centroid the block must return and clear the sums.
  task automatic track_pixel(input logic [X_W-1:0] px, input logic [Y_W-1:0] py,
                             input logic [CH_W-1:0] pu, input logic [CH_W-1:0] pv,
                             input logic last);
    int unsigned du;
    int unsigned dv;
    logic [SUM_W-1:0] quot;
    centroid_t c;
    if (lies_on_grid(px, shadow_cfg.sample_spacing, shadow_cfg.frame_width) &&
        lies_on_grid(py, shadow_cfg.sample_spacing, shadow_cfg.frame_height)) begin
      du = (pu > shadow_cfg.target_u) ? pu - shadow_cfg.target_u : shadow_cfg.target_u - pu;
      dv = (pv > shadow_cfg.target_v) ? pv - shadow_cfg.target_v : shadow_cfg.target_v - pv;
      // Drop matches once the count is saturated so sums stay consistent.
      if (du * du + dv * dv < shadow_cfg.match_threshold && hit_total != COUNT_MAX) begin
        col_sum   = col_sum + px;
        row_sum   = row_sum + py;
        hit_total = hit_total + 1'b1;
      end
    end
    if (last) begin
      c.count = hit_total;
      c.col   = '0;
      c.row   = '0;
      if (hit_total != 0) begin
        quot  = col_sum / hit_total;
        c.col = quot[X_W-1:0];
        quot  = row_sum / hit_total;
        c.row = quot[Y_W-1:0];
      end
      pending_centroids.push_back(c);
      col_sum   = '0;
      row_sum   = '0;
      hit_total = '0;
    end
  endtask

  // Predict on every accepted pixel beat.
  always @(posedge clk) begin
    if (!rst && pixel_in.valid && pixel_in.ready) begin
      pixels_accepted++;
      track_pixel(pixel_in.pixel_x, pixel_in.pixel_y, pixel_in.pixel_u, pixel_in.pixel_v,
                  pixel_in.last_pixel);
    end
  end

  // Compare every accepted result beat against the oldest owed centroid.
  always @(posedge clk) begin
    centroid_t want;
    if (!rst && result_out.valid && result_out.ready) begin
      results_seen++;
      if (pending_centroids.size() == 0) begin
        log_mismatch($sformatf("unexpected result count=%0d x=%0d y=%0d",
                               result_out.match_count, result_out.mean_col,
                               result_out.mean_row));
      end else begin
        want = pending_centroids.pop_front();
        if (result_out.match_count !== want.count)
          log_mismatch($sformatf("match_count %0d, want %0d", result_out.match_count,
                                 want.count));
        if (result_out.mean_col !== want.col)
          log_mismatch($sformatf("mean_col %0d, want %0d", result_out.mean_col, want.col));
        if (result_out.mean_row !== want.row)
          log_mismatch($sformatf("mean_row %0d, want %0d", result_out.mean_row, want.row));
      end
    end
  end

  // Result sink: stall at the rate of the current phase.
  always @(posedge clk) begin
    if (rst) begin
      result_out.ready <= 1'b0;
    end else begin
      result_out.ready <= ($urandom_range(99) >= sink_stall_pct);
    end
  end

  // APB write: setup cycle, then access cycle until pready; mirror into the shadow.
  task automatic write_reg(input reg_idx_t idx, input logic [CFG_DATA_W-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
    case (idx)
      REG_TARGET_U:  shadow_cfg.target_u        = value[CH_W-1:0];
      REG_TARGET_V:  shadow_cfg.target_v        = value[CH_W-1:0];
      REG_THRESHOLD: shadow_cfg.match_threshold = value[THR_W-1:0];
      REG_SPACING:   shadow_cfg.sample_spacing  = value[SP_W-1:0];
      REG_WIDTH:     shadow_cfg.frame_width     = value[DIM_W-1:0];
      REG_HEIGHT:    shadow_cfg.frame_height    = value[DIM_W-1:0];
      default: ;
    endcase
  endtask

  task automatic program_regs(input int unsigned tu, input int unsigned tv,
                              input int unsigned thr, input int unsigned sp,
                              input int unsigned w, input int unsigned h);
    write_reg(REG_TARGET_U, tu);
    write_reg(REG_TARGET_V, tv);
    write_reg(REG_THRESHOLD, thr);
    write_reg(REG_SPACING, sp);
    write_reg(REG_WIDTH, w);
    write_reg(REG_HEIGHT, h);
    settings_used++;
  endtask

  // Offer one pixel beat, idling first at the phase rate, and hold it until taken.
  // Leave valid high on return so back-to-back beats never toggle it within a step.
  task automatic send_pixel(input logic [X_W-1:0] x, input logic [Y_W-1:0] y,
                            input logic [CH_W-1:0] u, input logic [CH_W-1:0] v,
                            input logic last);
    while ($urandom_range(99) < sender_idle_pct) begin
      pixel_in.valid <= 1'b0;
      @(posedge clk);
    end
    pixel_in.valid      <= 1'b1;
    pixel_in.pixel_x    <= x;
    pixel_in.pixel_y    <= y;
    pixel_in.pixel_u    <= u;
    pixel_in.pixel_v    <= v;
    pixel_in.last_pixel <= last;
    do @(posedge clk); while (!pixel_in.ready);
  endtask

  // Drop valid and wait until every owed centroid has come back, then let any
  // trailing pixel with no result clear the pipeline. Registers may be written after.
  task automatic drain_block();
    pixel_in.valid <= 1'b0;
    do @(posedge clk); while (pending_centroids.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Mostly grid samples (including the last one inside the bound and the first
  // one past it), the rest anywhere in the 11-bit range.
  function automatic logic [X_W-1:0] pick_coord(input int unsigned dim);
    int unsigned b;
    int unsigned s;
    int unsigned h;
    int unsigned kmax;
    int unsigned c;
    b = (dim > FRAME_LIMIT) ? FRAME_LIMIT : dim;
    s = shadow_cfg.sample_spacing;
    h = s / 2;
    if (s == 0 || b < 2 * h || $urandom_range(9) >= 8) return $urandom_range(0, 2047);
    kmax = (b - 2 * h) / s;
    if ($urandom_range(9) < 6) c = $urandom_range(0, kmax) * s + h;
    else c = (kmax + $urandom_range(0, 1)) * s + h;
    return c[X_W-1:0];
  endfunction

  // Half the time near the target so matches are common, otherwise anywhere.
  function automatic logic [CH_W-1:0] pick_chroma(input logic [CH_W-1:0] t);
    int c;
    if ($urandom_range(1) != 0) return $urandom_range(0, 255);
    c = int'(t) + int'($urandom_range(0, 24)) - 12;
    if (c < 0) c = 0;
    if (c > 255) c = 255;
    return c[CH_W-1:0];
  endfunction

  task automatic send_random_frame(input int unsigned n);
    for (int i = 0; i < n; i++) begin
      send_pixel(pick_coord(shadow_cfg.frame_width), pick_coord(shadow_cfg.frame_height),
                 pick_chroma(shadow_cfg.target_u), pick_chroma(shadow_cfg.target_v),
                 i == n - 1);
    end
  endtask

  // Register defaults: grid limits at the bottom-right corner, distance equal to the threshold.
  task automatic test_reset_defaults();
    send_pixel(11'd4, 11'd4, 8'd120, 8'd197, 1'b0);        // exact target
    send_pixel(11'd1276, 11'd716, 8'd151, 8'd197, 1'b0);   // last grid point, distance 961
    send_pixel(11'd1284, 11'd4, 8'd120, 8'd197, 1'b0);     // one column past the bound
    send_pixel(11'd12, 11'd724, 8'd120, 8'd197, 1'b0);     // one row past the bound
    send_pixel(11'd20, 11'd20, 8'd152, 8'd197, 1'b0);      // distance equals threshold
    send_pixel(11'd2047, 11'd2047, 8'd0, 8'd255, 1'b1);    // off grid, closes frame
    drain_block();
  endtask

  // Tiny frame with the bound hit exactly, then the smallest and largest spacing.
  task automatic test_grid_bounds();
    program_regs(0, 255, 131071, 4, 8, 8);
    send_pixel(11'd2, 11'd2, 8'd0, 8'd255, 1'b0);
    send_pixel(11'd6, 11'd6, 8'd255, 8'd0, 1'b0);          // largest distance still matches
    send_pixel(11'd10, 11'd2, 8'd0, 8'd255, 1'b0);
    send_pixel(11'd6, 11'd10, 8'd0, 8'd255, 1'b0);
    send_pixel(11'd5, 11'd6, 8'd0, 8'd255, 1'b0);
    send_pixel(11'd0, 11'd0, 8'd0, 8'd255, 1'b1);
    drain_block();
    write_reg(REG_SPACING, 1);
    write_reg(REG_WIDTH, 2048);
    write_reg(REG_HEIGHT, 2048);
    settings_used++;
    send_pixel(11'd0, 11'd0, 8'd0, 8'd255, 1'b0);
    send_pixel(11'd2047, 11'd2047, 8'd0, 8'd255, 1'b1);
    drain_block();
    write_reg(REG_SPACING, 255);
    settings_used++;
    send_pixel(11'd1912, 11'd127, 8'd0, 8'd255, 1'b1);
    drain_block();
  endtask

  // Zero threshold never matches; check the strict compare right at the threshold.
  task automatic test_match_threshold();
    program_regs(200, 50, 0, 1, 2048, 2048);
    send_pixel(11'd5, 11'd5, 8'd200, 8'd50, 1'b1);
    drain_block();
    write_reg(REG_THRESHOLD, 25);
    settings_used++;
    send_pixel(11'd1, 11'd1, 8'd203, 8'd46, 1'b0);         // distance 25: no match
    send_pixel(11'd3, 11'd9, 8'd204, 8'd50, 1'b1);         // distance 16: match
    drain_block();
  endtask

  // Spacing of zero samples no pixel at all.
  task automatic test_zero_spacing();
    write_reg(REG_SPACING, 0);
    settings_used++;
    send_pixel(11'd0, 11'd0, 8'd200, 8'd50, 1'b0);
    send_pixel(11'd1, 11'd1, 8'd200, 8'd50, 1'b1);
    drain_block();
  endtask

  // Random frames over several register settings and all idle/stall mixes.
  task automatic test_random_frames();
    int unsigned per_phase;
    int unsigned sent;
    int unsigned n;
    int unsigned sp;
    int unsigned w;
    int unsigned h;
    int unsigned thr;
    per_phase = RANDOM_ITEMS / PHASES;
    for (int ph = 0; ph < PHASES; ph++) begin
      case ($urandom_range(4))
        0:       sp = 1;
        1:       sp = 255;
        2:       sp = $urandom_range(2, 4);
        3:       sp = 8;
        default: sp = $urandom_range(1, 255);
      endcase
      case ($urandom_range(3))
        0:       thr = 0;
        1:       thr = 131071;
        2:       thr = $urandom_range(1, 2000);
        default: thr = $urandom_range(0, 131071);
      endcase
      w = (ph == 0) ? 2048 : (ph == 1) ? 1 : $urandom_range(16, 2048);
      h = (ph == 0) ? 2048 : (ph == 1) ? 1 : $urandom_range(16, 2048);
      // Pin the first two phases to the target corners.
      program_regs((ph == 0) ? 0 : (ph == 1) ? 255 : $urandom_range(0, 255),
                   (ph == 0) ? 255 : (ph == 1) ? 0 : $urandom_range(0, 255), thr, sp, w, h);
      case (ph % 4)
        0: begin sender_idle_pct = 0;  sink_stall_pct = 0;  end
        1: begin sender_idle_pct = 70; sink_stall_pct = 0;  end
        2: begin sender_idle_pct = 0;  sink_stall_pct = 70; end
        default: begin sender_idle_pct = 11; sink_stall_pct = 11; end
      endcase
      sent = 0;
      while (sent < per_phase) begin
        n = ($urandom_range(9) == 0) ? $urandom_range(25, 80) : $urandom_range(1, 20);
        send_random_frame(n);
        sent += n;
      end
      // Hold off until every centroid is back before touching the registers.
      drain_block();
    end
  endtask

  initial begin
    rst                 = 1'b1;
    psel                = 1'b0;
    penable             = 1'b0;
    pwrite              = 1'b0;
    paddr               = '0;
    pwdata              = '0;
    pixel_in.valid      = 1'b0;
    pixel_in.pixel_x    = '0;
    pixel_in.pixel_y    = '0;
    pixel_in.pixel_u    = '0;
    pixel_in.pixel_v    = '0;
    pixel_in.last_pixel = 1'b0;
    result_out.ready    = 1'b0;
    sender_idle_pct     = 0;
    sink_stall_pct      = 0;
    error_count         = 0;
    pixels_accepted     = 0;
    results_seen        = 0;
    settings_used       = 1;
    // Register defaults and cleared accumulators after reset.
    shadow_cfg.target_u        = 8'd120;
    shadow_cfg.target_v        = 8'd197;
    shadow_cfg.match_threshold = 17'd1024;
    shadow_cfg.sample_spacing  = 8'd8;
    shadow_cfg.frame_width     = 12'd1280;
    shadow_cfg.frame_height    = 12'd720;
    col_sum   = '0;
    row_sum   = '0;
    hit_total = '0;

    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_reset_defaults();
    test_grid_bounds();
    test_match_threshold();
    test_zero_spacing();
    test_random_frames();

    $display("run covered %0d pixel beats and %0d frame results over %0d register settings",
             pixels_accepted, results_seen, settings_used);
    if (error_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

@@ sim.f @@
rtl/cmc_pkg.sv
rtl/cmc_pixel_if.sv
rtl/cmc_result_if.sv
rtl/cmc_front.sv
rtl/cmc_queue.sv
rtl/cmc_back.sv
rtl/chroma_match_centroid.sv
test/testbench.sv
